// ----- src/alpha_over_blend_defines.svh -----
// ----------------------------------------------------------------------------
// alpha over blend assertion macros
// shared concurrent assertion forms for the blend checker
// ----------------------------------------------------------------------------
`ifndef ALPHA_OVER_BLEND_DEFINES_SVH
`define ALPHA_OVER_BLEND_DEFINES_SVH

// same-cycle implication
`define AOB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aob same-cycle check failed");

// next-cycle implication
`define AOB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aob next-cycle check failed");

`endif

// ----- src/aob_pkg.sv -----
// ----------------------------------------------------------------------------
// aob_pkg
// widths, constants and shared types of the alpha over blend pipeline
// ----------------------------------------------------------------------------
package aob_pkg;

  localparam int unsigned PixW      = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned WghtW     = 16;
  localparam int unsigned NumW      = 24;
  localparam int unsigned Lanes     = 3;
  localparam int unsigned DivStages = 8;
  localparam int unsigned InW       = 2 * PixW;
  localparam int unsigned AlphaMulW = 26;

  localparam logic [ByteW-1:0]     ByteMax  = 8'hFF;
  localparam logic [AlphaMulW-1:0] AlphaMul = 26'd257;

  // one word in flight through the divider
  typedef struct packed {
    logic [Lanes-1:0][NumW-1:0]  rem;
    logic [Lanes-1:0][ByteW-1:0] quo;
    logic [WghtW-1:0]            den;
    logic [ByteW-1:0]            alpha;
    logic                        zero;
  } div_word_t;

endpackage

// ----- src/aob_front.sv -----
// ----------------------------------------------------------------------------
// aob_front
// three register stages: weights, products, then numerators, alpha and zero
// ----------------------------------------------------------------------------
module aob_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [aob_pkg::PixW-1:0]      src_i,
  input  logic [aob_pkg::PixW-1:0]      dst_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output aob_pkg::div_word_t            out_o
);

  localparam int unsigned BW = aob_pkg::ByteW;
  localparam int unsigned WW = aob_pkg::WghtW;
  localparam int unsigned NW = aob_pkg::NumW;
  localparam int unsigned LN = aob_pkg::Lanes;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic [WW-1:0]          ws_d, wd_d, ws_q, wd_q;
  logic [LN-1:0][BW-1:0]  cs_q, cd_q;
  logic [LN-1:0][NW-1:0]  ps_d, pd_d, ps_q, pd_q;
  logic [WW-1:0]          den_d, den_q;
  logic [BW-1:0]          as_w, ad_w, inv_as;
  logic [aob_pkg::AlphaMulW-1:0] amul;
  aob_pkg::div_word_t     word_d, word_q;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: source and destination weights
  assign as_w   = src_i[aob_pkg::PixW-1 -: BW];
  assign ad_w   = dst_i[aob_pkg::PixW-1 -: BW];
  assign inv_as = aob_pkg::ByteMax - as_w;
  assign ws_d   = {as_w, {BW{1'b0}}} - WW'(as_w);
  assign wd_d   = WW'(ad_w) * WW'(inv_as);

  // stage 2: per-lane products and the denominator
  always_comb begin
    for (int c = 0; c < LN; c++) begin
      ps_d[c] = NW'(cs_q[c]) * NW'(ws_q);
      pd_d[c] = NW'(cd_q[c]) * NW'(wd_q);
    end
    den_d = WW'(ws_q + wd_q);
  end

  // stage 3: numerators, alpha by reciprocal of 255, zero flag
  assign amul = (aob_pkg::AlphaMulW'(den_q) + aob_pkg::AlphaMulW'(1)) * aob_pkg::AlphaMul;

  always_comb begin
    for (int c = 0; c < LN; c++) begin
      word_d.rem[c] = ps_q[c] + pd_q[c];
      word_d.quo[c] = '0;
    end
    word_d.den   = den_q;
    word_d.alpha = amul[2*BW +: BW];
    word_d.zero  = (den_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      ws_q <= ws_d;
      wd_q <= wd_d;
      for (int c = 0; c < LN; c++) begin
        cs_q[c] <= src_i[c*BW +: BW];
        cd_q[c] <= dst_i[c*BW +: BW];
      end
    end
    if (rdy2 && v1_q) begin
      ps_q  <= ps_d;
      pd_q  <= pd_d;
      den_q <= den_d;
    end
    if (rdy3 && v2_q) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = word_q;

endmodule

// ----- src/aob_div_stage.sv -----
// ----------------------------------------------------------------------------
// aob_div_stage
// one restoring division step: one quotient bit for each colour lane
// ----------------------------------------------------------------------------
module aob_div_stage #(
  parameter int unsigned BIT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  aob_pkg::div_word_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output aob_pkg::div_word_t out_o
);

  localparam int unsigned NW = aob_pkg::NumW;
  localparam int unsigned BW = aob_pkg::ByteW;

  logic               v_q;
  logic               rdy;
  logic [NW-1:0]      dsh;
  aob_pkg::div_word_t word_d, word_q;

  assign rdy        = !v_q || out_ready_i;
  assign in_ready_o = rdy;
  assign dsh        = NW'(in_i.den) << BIT;

  always_comb begin
    word_d = in_i;
    for (int c = 0; c < aob_pkg::Lanes; c++) begin
      if (in_i.rem[c] >= dsh) begin
        word_d.rem[c] = in_i.rem[c] - dsh;
        word_d.quo[c] = {in_i.quo[c][BW-2:0], 1'b1};
      end else begin
        word_d.quo[c] = {in_i.quo[c][BW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_o       = word_q;

endmodule

// ----- src/alpha_over_blend.sv -----
// ----------------------------------------------------------------------------
// alpha_over_blend
// source-over-destination compositing of straight-alpha argb8888 pixels
// ----------------------------------------------------------------------------
// the slave channel takes one pixel pair per word: source pixel in tdata
// bits 31:0, destination pixel in bits 63:32, alpha in the top byte of each.
// the master channel gives one composited argb pixel per word.
// one pair enters per clock unless the master side stalls; each word passes
// through three stages for weights, products and numerators, eight restoring
// divider stages (one quotient bit each, shared denominator for the three
// colour lanes) and the output register.
// the divider chain sets throughput: a new word every cycle unless stalled.
// every stage holds its own valid bit, so bubbles close up and input is still
// taken while a finished pixel waits on tready.
// when tready stays low, each stage holds its word and nothing is dropped or
// repeated; tready on the slave side falls only once every stage is full.
// reset clears all valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module alpha_over_blend (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // new_pixel [31:0], current_pixel [63:32]
  input  logic [aob_pkg::InW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // blended_pixel [31:0]
  output logic [aob_pkg::PixW-1:0] m_axis_tdata
);

  localparam int unsigned DS = aob_pkg::DivStages;

  aob_pkg::div_word_t      dw   [DS+1];
  logic [DS:0]             dv;
  logic [DS:0]             dr;
  logic                    out_v_q;
  logic                    out_rdy;
  logic [aob_pkg::PixW-1:0] pix_d, pix_q;

  aob_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .src_i       (s_axis_tdata[aob_pkg::PixW-1:0]),
    .dst_i       (s_axis_tdata[aob_pkg::InW-1:aob_pkg::PixW]),
    .out_valid_o (dv[0]),
    .out_ready_i (dr[0]),
    .out_o       (dw[0])
  );

  for (genvar k = 0; k < DS; k++) begin : g_div
    aob_div_stage #(
      .BIT (DS - 1 - k)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv[k]),
      .in_ready_o  (dr[k]),
      .in_i        (dw[k]),
      .out_valid_o (dv[k+1]),
      .out_ready_i (dr[k+1]),
      .out_o       (dw[k+1])
    );
  end

  // output register, zero pixel when both alphas are zero
  assign out_rdy = !out_v_q || m_axis_tready;
  assign dr[DS]  = out_rdy;

  always_comb begin
    pix_d = {dw[DS].alpha, dw[DS].quo[2], dw[DS].quo[1], dw[DS].quo[0]};
    if (dw[DS].zero) begin
      pix_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dv[DS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && dv[DS]) begin
      pix_q <= pix_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = pix_q;

endmodule

// ----- src/aob_checker.sv -----
// ----------------------------------------------------------------------------
// aob_checker
// port-level checks on the alpha over blend block, bound to the top level
// ----------------------------------------------------------------------------
`include "alpha_over_blend_defines.svh"

module aob_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [aob_pkg::PixW-1:0] m_axis_tdata
);

  localparam int unsigned PW = aob_pkg::PixW;
  localparam int unsigned BW = aob_pkg::ByteW;

  // zero output alpha only comes from two transparent inputs
  `AOB_ASSERT_IMP(a_zero_alpha_zero_pixel, m_axis_tvalid && (m_axis_tdata[PW-1 -: BW] == '0), m_axis_tdata == '0)

  // input back-pressure only once the output holds a word
  `AOB_ASSERT_IMP(a_ready_low_output_full, !s_axis_tready, m_axis_tvalid)

  // stalled output word is held
  `AOB_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // no output word straight after reset
  `AOB_ASSERT_NXT(a_out_empty_after_rst, $rose(rst_ni), !m_axis_tvalid)

endmodule

bind alpha_over_blend aob_checker u_aob_checker (.*);
